// ===== hdl/swlp_pkg.sv =====
// Shared types and constants of the sliding window latency monitor.
package swlp_pkg;

  localparam int SAMPLE_W = 32;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // floor(n*pct/100) as (n * pct * ceil(2^26/100)) >> 26; exact while n*pct < 1.8e6
  localparam int               RCP_W   = 26;
  localparam int               RCP_SH  = 26;
  localparam logic [RCP_W-1:0] RCP_P95 = 26'd63753455;
  localparam logic [RCP_W-1:0] RCP_P99 = 26'd66437811;
  localparam int               PCT_DEN = 100;

  typedef struct packed {
    logic                op;
    logic [SAMPLE_W-1:0] sample;
  } req_t;

endpackage

// ===== hdl/swlp_in_if.sv =====
// Input request channel: valid/ready with opcode and sample.
interface swlp_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] sample_us;

  modport source (output valid, output op, output sample_us, input ready);
  modport sink   (input valid, input op, input sample_us, output ready);
endinterface

// ===== hdl/swlp_out_if.sv =====
// Result channel: valid/ready with window statistics.
interface swlp_out_if #(parameter int CW = 9);
  logic          valid;
  logic          ready;
  logic [CW-1:0] sample_count;
  logic [31:0]   mean_us;
  logic [31:0]   median_us;
  logic [31:0]   pct95_us;
  logic [31:0]   pct99_us;
  logic [31:0]   peak_us;

  modport source (output valid, output sample_count, output mean_us, output median_us,
                  output pct95_us, output pct99_us, output peak_us, input ready);
  modport sink   (input valid, input sample_count, input mean_us, input median_us,
                  input pct95_us, input pct99_us, input peak_us, output ready);
endinterface

// ===== hdl/swlp_front.sv =====
// Front end: accepts requests, decodes the opcode bit, two-entry queue to the back end.
module swlp_front (
  input  logic              clk,
  input  logic              rst_n,
  swlp_in_if.sink           in_ch,
  output swlp_pkg::req_t    q_req,
  output logic              q_valid,
  input  logic              q_ready
);

  swlp_pkg::req_t ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  logic       pop;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign pop         = q_valid && q_ready;
  assign q_req       = ent_r[rd_ptr_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r].op     <= (in_ch.op == swlp_pkg::OP_QUERY);
      ent_r[wr_ptr_r].sample <= in_ch.sample_us;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== hdl/swlp_div.sv =====
// Restoring divider, one quotient bit per cycle.
module swlp_div #(
  parameter int DW = 40
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNT_W = $clog2(DW);

  logic [DW:0]      rem_r;
  logic [DW-1:0]    quo_r;
  logic [DW-1:0]    den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DW:0]      sh;
  logic [DW+1:0]    diff;
  logic [DW:0]      rem_nxt;
  logic [DW-1:0]    quo_nxt;

  // one shift-subtract step
  always_comb begin
    sh   = {rem_r[DW-1:0], quo_r[DW-1]};
    diff = {1'b0, sh} - {2'b00, den_r};
    if (!diff[DW+1]) begin
      rem_nxt = diff[DW:0];
      quo_nxt = {quo_r[DW-2:0], 1'b1};
    end else begin
      rem_nxt = sh;
      quo_nxt = {quo_r[DW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= divisor;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == CNT_W'(DW - 1))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== hdl/swlp_back.sv =====
// Back end: sample window memory, record update, mean and rank-based order statistics.
module swlp_back #(
  parameter int WINDOW_DEPTH = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  swlp_pkg::req_t q_req,
  input  logic           q_valid,
  output logic           q_ready,
  swlp_out_if.source     out_ch
);

  localparam int PW = $clog2(WINDOW_DEPTH);
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int SW = swlp_pkg::SAMPLE_W;
  localparam int DW = SW + PW;
  localparam int MW = CW + swlp_pkg::RCP_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_REC   = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [SW-1:0] mem [WINDOW_DEPTH];
  logic [SW-1:0] rd_a_r;
  logic [SW-1:0] rd_b_r;
  logic [PW-1:0] addr_a;
  logic          mem_we;

  logic [2:0]    state_r;
  logic [CW-1:0] fill_r;
  logic [PW-1:0] wp_r;
  logic [DW-1:0] sum_r;
  logic [SW-1:0] peak_r;
  logic [SW-1:0] smp_r;
  logic [PW-1:0] i_r;
  logic [PW-1:0] j_r;
  logic [PW-1:0] rank_r;
  logic          cmp_vld_r;
  logic [PW-1:0] cmp_j_r;
  logic [PW-1:0] idx95_r;
  logic [PW-1:0] idx99_r;

  logic          out_vld_r;
  logic [CW-1:0] cnt_o_r;
  logic [SW-1:0] mean_r;
  logic [SW-1:0] med_r;
  logic [SW-1:0] p95_r;
  logic [SW-1:0] p99_r;
  logic [SW-1:0] peak_o_r;

  logic          div_start;
  logic [DW-1:0] div_dvd;
  logic [DW-1:0] div_dvs;
  logic          div_done;
  logic [DW-1:0] div_q;

  logic          full;
  logic [PW-1:0] wp_nxt;
  logic [CW-1:0] fill_m1;
  logic [PW-1:0] n_m1;
  logic [PW-1:0] idx50;
  logic [MW-1:0] prod95;
  logic [MW-1:0] prod99;
  logic [PW-1:0] k95;
  logic [PW-1:0] k99;
  logic [PW-1:0] idx95;
  logic [PW-1:0] idx99;
  logic          lt;
  logic [PW-1:0] rank_acc;
  logic [DW-1:0] old_val;

  assign full    = (fill_r == CW'(WINDOW_DEPTH));
  assign wp_nxt  = (wp_r == PW'(WINDOW_DEPTH - 1)) ? '0 : (wp_r + PW'(1));
  assign fill_m1 = fill_r - CW'(1);
  assign n_m1    = fill_m1[PW-1:0];
  assign idx50   = PW'(fill_r >> 1);
  assign old_val = full ? DW'(rd_a_r) : '0;

  // percent ranks by reciprocal multiply, index clamped at zero
  assign prod95 = MW'(fill_r) * MW'(swlp_pkg::RCP_P95);
  assign prod99 = MW'(fill_r) * MW'(swlp_pkg::RCP_P99);
  assign k95    = prod95[swlp_pkg::RCP_SH +: PW];
  assign k99    = prod99[swlp_pkg::RCP_SH +: PW];
  assign idx95  = (k95 == '0) ? '0 : (k95 - PW'(1));
  assign idx99  = (k99 == '0) ? '0 : (k99 - PW'(1));

  assign q_ready = (state_r == ST_IDLE);
  assign addr_a  = (state_r == ST_IDLE) ? wp_r : i_r;
  assign mem_we  = (state_r == ST_REC);

  // stable rank comparison: smaller, or equal and earlier in the window
  assign lt       = (rd_b_r < rd_a_r) || ((rd_b_r == rd_a_r) && (cmp_j_r < i_r));
  assign rank_acc = rank_r + PW'(cmp_vld_r && lt);

  // window memory, one write and two registered reads
  always_ff @(posedge clk) begin
    if (mem_we) mem[wp_r] <= smp_r;
    rd_a_r <= mem[addr_a];
    rd_b_r <= mem[j_r];
  end

  // divider request: mean of the held samples
  assign div_start = (state_r == ST_IDLE) && q_valid &&
                     (q_req.op == swlp_pkg::OP_QUERY) && (fill_r != '0);
  assign div_dvd   = sum_r;
  assign div_dvs   = DW'(fill_r);

  swlp_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  // payload and working registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        smp_r <= q_req.sample;
        if (q_valid && (q_req.op == swlp_pkg::OP_QUERY) && (fill_r == '0)) begin
          cnt_o_r  <= '0;
          mean_r   <= '0;
          med_r    <= '0;
          p95_r    <= '0;
          p99_r    <= '0;
          peak_o_r <= '0;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          mean_r  <= div_q[SW-1:0];
          idx95_r <= idx95;
          idx99_r <= idx99;
          i_r     <= '0;
          j_r     <= '0;
          rank_r  <= '0;
        end
      end
      ST_SCAN: begin
        rank_r  <= rank_acc;
        cmp_j_r <= j_r;
        if (j_r != n_m1) j_r <= j_r + PW'(1);
      end
      ST_DRAIN: begin
        if (rank_acc == idx50)   med_r <= rd_a_r;
        if (rank_acc == idx95_r) p95_r <= rd_a_r;
        if (rank_acc == idx99_r) p99_r <= rd_a_r;
        i_r    <= i_r + PW'(1);
        j_r    <= '0;
        rank_r <= '0;
        cnt_o_r  <= fill_r;
        peak_o_r <= peak_r;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      fill_r    <= '0;
      wp_r      <= '0;
      sum_r     <= '0;
      peak_r    <= '0;
      cmp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_req.op == swlp_pkg::OP_RECORD) begin
              state_r <= ST_REC;
            end else if (fill_r == '0) begin
              out_vld_r <= 1'b1;
              state_r   <= ST_OUT;
            end else begin
              state_r <= ST_DIV;
            end
          end
        end
        ST_REC: begin
          sum_r <= sum_r - old_val + DW'(smp_r);
          if (!full) fill_r <= fill_r + CW'(1);
          wp_r <= wp_nxt;
          if (smp_r > peak_r) peak_r <= smp_r;
          state_r <= ST_IDLE;
        end
        ST_DIV: if (div_done) state_r <= ST_SCAN;
        ST_SCAN: begin
          cmp_vld_r <= 1'b1;
          if (j_r == n_m1) state_r <= ST_DRAIN;
        end
        ST_DRAIN: begin
          cmp_vld_r <= 1'b0;
          if (i_r == n_m1) begin
            out_vld_r <= 1'b1;
            state_r   <= ST_OUT;
          end else begin
            state_r <= ST_SCAN;
          end
        end
        ST_OUT: begin
          if (out_ch.ready) begin
            out_vld_r <= 1'b0;
            state_r   <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.sample_count = cnt_o_r;
  assign out_ch.mean_us      = mean_r;
  assign out_ch.median_us    = med_r;
  assign out_ch.pct95_us     = p95_r;
  assign out_ch.pct99_us     = p99_r;
  assign out_ch.peak_us      = peak_o_r;

endmodule

// ===== hdl/sliding_window_latency_percentiles.sv =====
// Record: window, sum and peak updated in the back end's REC state after it takes the request; no result.
// Query: the result follows a mean divide and a rank scan (PW = log2 WINDOW_DEPTH):
//   a (32+PW)-step mean divider, then a rank scan over n held samples, each ranked against
//   every held sample through the single window read port pair.
// Empty-window query: zero result registered from the idle state. One request is worked at a time;
//   a two-entry queue keeps accepting while a result waits on the output.
// Reset (synchronous, active low) clears count, pointer, sum, peak and handshakes; the
//   window memory is not cleared, only written entries are ever read.
module sliding_window_latency_percentiles #(
  parameter int WINDOW_DEPTH = 256
) (
  input logic        clk,
  input logic        rst_n,
  swlp_in_if.sink    in_ch,
  swlp_out_if.source out_ch
);

  swlp_pkg::req_t q_req;
  logic           q_valid;
  logic           q_ready;

  swlp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_req   (q_req),
    .q_valid (q_valid),
    .q_ready (q_ready)
  );

  swlp_back #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_req   (q_req),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .out_ch  (out_ch)
  );

endmodule

// ===== tb/sliding_window_latency_percentiles_tb.sv =====
// Testbench for the sliding window latency percentile monitor.
`timescale 1ns / 1ps

module sliding_window_latency_percentiles_tb;

  localparam int DEPTH      = 256;
  localparam int IDLE_LIMIT = 300000;

  typedef struct {
    logic                          op;
    logic [swlp_pkg::SAMPLE_W-1:0] sample;
    bit                            drain;
  } stim_t;

  typedef struct {
    logic [8:0]                    count;
    logic [swlp_pkg::SAMPLE_W-1:0] mean;
    logic [swlp_pkg::SAMPLE_W-1:0] p50;
    logic [swlp_pkg::SAMPLE_W-1:0] p95;
    logic [swlp_pkg::SAMPLE_W-1:0] p99;
    logic [swlp_pkg::SAMPLE_W-1:0] peak;
  } stats_t;

  logic clk;
  logic rst_n;

  swlp_in_if            in_ch ();
  swlp_out_if #(.CW(9)) out_ch ();

  sliding_window_latency_percentiles #(.WINDOW_DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Pending requests and expected window statistics
  stim_t  pending_reqs[$];
  stats_t expected_stats[$];
  int     errors;
  bit     req_taken;

  // Shadow window state
  logic [swlp_pkg::SAMPLE_W-1:0] shadow_win[DEPTH];
  int                            shadow_fill;
  int                            shadow_wp;
  logic [39:0]                   shadow_sum;
  logic [swlp_pkg::SAMPLE_W-1:0] shadow_peak;

  // Generator-side count of recorded samples
  int gen_fill;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int pct_slot(int n, int pct);
    int k;
    k = (n * pct) / swlp_pkg::PCT_DEN;
    return (k == 0) ? 0 : k - 1;
  endfunction

  // Apply one request to the shadow window; queue stats for a query
  task automatic track_request(logic op, logic [swlp_pkg::SAMPLE_W-1:0] us);
    logic [swlp_pkg::SAMPLE_W-1:0] sorted[DEPTH];
    logic [swlp_pkg::SAMPLE_W-1:0] v;
    stats_t                        st;
    int                            j;
    if (op == swlp_pkg::OP_RECORD) begin
      if (shadow_fill < DEPTH) begin
        shadow_sum  = shadow_sum + 40'(us);
        shadow_fill = shadow_fill + 1;
      end else begin
        shadow_sum = shadow_sum - 40'(shadow_win[shadow_wp]) + 40'(us);
      end
      shadow_win[shadow_wp] = us;
      shadow_wp = (shadow_wp + 1) % DEPTH;
      if (us > shadow_peak) shadow_peak = us;
    end else begin
      st = '{default: '0};
      if (shadow_fill > 0) begin
        // insertion sort of the held samples
        for (int i = 0; i < shadow_fill; i++) begin
          v = shadow_win[i];
          j = i;
          while (j > 0 && sorted[j-1] > v) begin
            sorted[j] = sorted[j-1];
            j--;
          end
          sorted[j] = v;
        end
        st.count = 9'(shadow_fill);
        st.mean  = 32'(shadow_sum / 40'(shadow_fill));
        st.p50   = sorted[shadow_fill / 2];
        st.p95   = sorted[pct_slot(shadow_fill, 95)];
        st.p99   = sorted[pct_slot(shadow_fill, 99)];
        st.peak  = shadow_peak;
      end
      expected_stats.push_back(st);
    end
  endtask

  function automatic logic [swlp_pkg::SAMPLE_W-1:0] pick_latency();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 15);
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          2: return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
      2: return 32'hFFFF_0000 | $urandom_range(0, 65535);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_req(logic op, logic [swlp_pkg::SAMPLE_W-1:0] us, bit drain);
    stim_t s;
    s.op = op;
    s.sample = us;
    s.drain = drain;
    pending_reqs.push_back(s);
    if (op == swlp_pkg::OP_RECORD && gen_fill < DEPTH) gen_fill++;
  endtask

  // Sender: bursts of random length, random gaps
  int burst_left;
  int gap_left;

  always @(negedge clk) begin
    stim_t nxt;
    if (rst_n) begin
      if (in_ch.valid && !req_taken) begin
        // hold the current request
      end else if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_reqs.size() > 0 &&
                   (!pending_reqs[0].drain || expected_stats.size() == 0)) begin
        nxt = pending_reqs.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.op        <= nxt.op;
        in_ch.sample_us <= nxt.sample;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern with modes that change over time
  int ready_mode;
  int mode_left;

  always @(negedge clk) begin
    if (rst_n) begin
      if (mode_left <= 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(5, 60);
      end
      mode_left--;
      case (ready_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= (mode_left % 8) < 3;
      endcase
    end
  end

  // Monitor: check results, then track accepted requests
  int idle_cycles;

  always @(posedge clk) begin
    stats_t e;
    bit     moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        if (expected_stats.size() == 0) begin
          $display("%0t: result without pending query: count=%0d", $time, out_ch.sample_count);
          errors++;
        end else begin
          e = expected_stats.pop_front();
          if (out_ch.sample_count !== e.count) begin
            $display("%0t: sample_count exp %0d got %0d", $time, e.count, out_ch.sample_count);
            errors++;
          end
          if (out_ch.mean_us !== e.mean) begin
            $display("%0t: mean_us exp %h got %h", $time, e.mean, out_ch.mean_us);
            errors++;
          end
          if (out_ch.median_us !== e.p50) begin
            $display("%0t: median_us exp %h got %h", $time, e.p50, out_ch.median_us);
            errors++;
          end
          if (out_ch.pct95_us !== e.p95) begin
            $display("%0t: pct95_us exp %h got %h", $time, e.p95, out_ch.pct95_us);
            errors++;
          end
          if (out_ch.pct99_us !== e.p99) begin
            $display("%0t: pct99_us exp %h got %h", $time, e.p99, out_ch.pct99_us);
            errors++;
          end
          if (out_ch.peak_us !== e.peak) begin
            $display("%0t: peak_us exp %h got %h", $time, e.peak, out_ch.peak_us);
            errors++;
          end
        end
      end
      req_taken = in_ch.valid && in_ch.ready;
      if (req_taken) begin
        moved = 1'b1;
        track_request(in_ch.op, in_ch.sample_us);
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = swlp_pkg::OP_RECORD;
    in_ch.sample_us = '0;
    out_ch.ready = 1'b0;
    errors = 0;
    req_taken = 1'b0;
    shadow_fill = 0;
    shadow_wp = 0;
    shadow_sum = '0;
    shadow_peak = '0;
    gen_fill = 0;
    burst_left = 1;
    gap_left = 0;
    ready_mode = 0;
    mode_left = 0;
    idle_cycles = 0;

    // Directed: empty window, small counts with clamped indices, extremes
    add_req(swlp_pkg::OP_QUERY, 32'hFFFF_FFFF, 1'b0);
    add_req(swlp_pkg::OP_RECORD, 32'h0000_0000, 1'b0);
    add_req(swlp_pkg::OP_QUERY, 32'h0, 1'b0);
    add_req(swlp_pkg::OP_RECORD, 32'hFFFF_FFFF, 1'b0);
    add_req(swlp_pkg::OP_QUERY, 32'h0, 1'b0);
    add_req(swlp_pkg::OP_RECORD, 32'h0000_0001, 1'b0);
    add_req(swlp_pkg::OP_RECORD, 32'h7FFF_FFFF, 1'b0);
    add_req(swlp_pkg::OP_QUERY, 32'h5555_5555, 1'b0);
    add_req(swlp_pkg::OP_RECORD, 32'h8000_0000, 1'b0);
    add_req(swlp_pkg::OP_QUERY, 32'hAAAA_AAAA, 1'b0);
    add_req(swlp_pkg::OP_RECORD, 32'hFFFF_FFFF, 1'b0);
    add_req(swlp_pkg::OP_QUERY, 32'h0, 1'b1);
    add_req(swlp_pkg::OP_RECORD, 32'h0000_0000, 1'b0);
    add_req(swlp_pkg::OP_QUERY, 32'h0, 1'b0);

    // Random, small windows: cheap queries
    while (gen_fill < 40) begin
      if ($urandom_range(0, 1)) add_req(swlp_pkg::OP_QUERY, $urandom, 1'b0);
      else add_req(swlp_pkg::OP_RECORD, pick_latency(), 1'b0);
    end
    add_req(swlp_pkg::OP_QUERY, $urandom, 1'b1);

    // Fill the window with three mid-size checks
    while (gen_fill < 100) add_req(swlp_pkg::OP_RECORD, pick_latency(), 1'b0);
    add_req(swlp_pkg::OP_QUERY, $urandom, 1'b0);
    while (gen_fill < 200) add_req(swlp_pkg::OP_RECORD, pick_latency(), 1'b0);
    add_req(swlp_pkg::OP_QUERY, $urandom, 1'b0);
    while (gen_fill < 255) add_req(swlp_pkg::OP_RECORD, pick_latency(), 1'b0);
    add_req(swlp_pkg::OP_QUERY, $urandom, 1'b0);

    // Full window with wraparound: queries are slow, keep them rare
    for (int i = 0; i < 1050; i++) begin
      add_req(swlp_pkg::OP_RECORD, pick_latency(), 1'b0);
      if (i % 175 == 174) add_req(swlp_pkg::OP_QUERY, $urandom, (i % 350) == 349);
    end
    add_req(swlp_pkg::OP_QUERY, $urandom, 1'b0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (pending_reqs.size() == 0 && !in_ch.valid);
    wait (expected_stats.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_stats.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
